### design/assert_macros.svh
// Assertion macros shared by the heap queue RTL.
// Clock and reset names come from the including module (clk, rst).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/mhpq_pkg.sv
// Shared types and codes for the max-heap priority queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  localparam int DEFAULT_CAPACITY = 64;

  typedef logic signed [31:0] key_t;
  typedef logic [1:0]         status_t;

  localparam logic    CMD_INSERT = 1'b0;
  localparam logic    CMD_REMOVE = 1'b1;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

### design/max_heap_priority_queue_top.sv
// Max-heap priority queue: insert sifts up in S_UP; remove loads root and last entry
// in S_RM_LOAD, then sifts down in S_DOWN; a key moves at most log2(CAPACITY) levels.
// Removing the only key reports from S_RM_LOAD; full-insert / empty-remove from S_IDLE.
// One request at a time; the sift loop (one read and compare per level) sets the rate.
// rst clears the internal key count; store contents are not cleared (no clearing pass).
// Results show for one cycle on done; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module max_heap_priority_queue_top #(
  parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire mhpq_pkg::key_t key,
  output logic             done,
  output mhpq_pkg::key_t   removed_key,
  output mhpq_pkg::status_t status,
  output logic [6:0]       entry_count
);
  import mhpq_pkg::*;

  // AW indexes a slot, CW holds a count up to CAPACITY, XW holds a child
  // index 2*i+2 without wrapping.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  // Sequencer states
  localparam logic [1:0] S_IDLE    = 2'd0;  // waiting for a request
  localparam logic [1:0] S_UP      = 2'd1;  // sift-up, one level per cycle
  localparam logic [1:0] S_RM_LOAD = 2'd2;  // root and last entry arriving
  localparam logic [1:0] S_DOWN    = 2'd3;  // sift-down, one level per cycle

  logic [1:0]    state;
  logic [CW-1:0] count;     // keys held
  logic [AW-1:0] pos;       // hole the moving key currently sits in
  key_t          hold_key;  // key being sifted

  // RAM ports
  logic          we;
  logic [AW-1:0] waddr;
  key_t          wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  key_t          rdata_a;
  key_t          rdata_b;

  mhpq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign busy = (state != S_IDLE);

  logic accept;
  assign accept = start && !busy;

  // ---- index arithmetic ----
  logic [CW-1:0] count_m1;
  logic [XW-1:0] count_x;
  logic [AW-1:0] pos_m1;
  logic [AW-1:0] parent;       // (pos-1)/2
  logic [AW-1:0] parent_m1;
  logic [AW-1:0] grandparent;  // parent of parent, read ahead of the next level
  logic [XW-1:0] child_l;      // 2*pos+1
  logic [XW-1:0] child_r;      // 2*pos+2

  assign count_m1    = count - CW'(1);
  assign count_x     = XW'(count);
  assign pos_m1      = pos - AW'(1);
  assign parent      = AW'(pos_m1 >> 1);
  assign parent_m1   = parent - AW'(1);
  assign grandparent = AW'(parent_m1 >> 1);
  assign child_l     = {1'b0, pos, 1'b1};
  assign child_r     = child_l + XW'(1);

  // ---- sift-up decision ----
  // stop at the root or once the parent is not strictly smaller
  logic up_stop;
  assign up_stop = (pos == '0) || !(hold_key > rdata_a);

  // ---- sift-down decision ----
  // left child wins ties; move only if the chosen child is strictly larger
  logic          left_ok;
  logic          right_ok;
  logic          pick_r;
  logic [XW-1:0] pick_idx;
  key_t          pick_val;
  logic          down_move;
  logic [AW-1:0] pick_pos;
  logic [XW-1:0] next_l;
  logic [XW-1:0] next_r;

  assign left_ok   = child_l < count_x;
  assign right_ok  = child_r < count_x;
  assign pick_r    = right_ok && (rdata_b > rdata_a);
  assign pick_idx  = pick_r ? child_r : child_l;
  assign pick_val  = pick_r ? rdata_b : rdata_a;
  assign down_move = left_ok && (pick_val > hold_key);
  assign pick_pos  = pick_idx[AW-1:0];
  assign next_l    = {1'b0, pick_pos, 1'b1};
  assign next_r    = next_l + XW'(1);

  // ---- RAM port steering ----
  always_comb begin
    we      = 1'b0;
    waddr   = pos;
    wdata   = hold_key;
    raddr_a = '0;
    raddr_b = '0;
    case (state)
      S_IDLE: begin
        if (command == CMD_INSERT) begin
          // parent of the new slot; junk when the heap is empty, ignored then
          raddr_a = AW'(count_m1 >> 1);
        end else begin
          raddr_a = '0;                 // root
          raddr_b = AW'(count_m1);      // last entry
        end
      end
      S_UP: begin
        we = 1'b1;
        if (!up_stop) begin
          wdata = rdata_a;              // pull parent down into the hole
        end
        raddr_a = grandparent;
      end
      S_RM_LOAD: begin
        raddr_a = AW'(1);
        raddr_b = AW'(2);
      end
      S_DOWN: begin
        we = 1'b1;
        if (down_move) begin
          wdata = pick_val;             // pull child up into the hole
        end
        raddr_a = next_l[AW-1:0];
        raddr_b = next_r[AW-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // ---- sequencer and result registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            removed_key <= '0;
            hold_key    <= key;
            pos         <= AW'(count);
            if (command == CMD_INSERT) begin
              if (count >= CW'(CAPACITY)) begin
                done        <= 1'b1;
                status      <= STATUS_FULL;
                entry_count <= 7'(count);
              end else begin
                state <= S_UP;
              end
            end else begin
              if (count == '0) begin
                done        <= 1'b1;
                status      <= STATUS_EMPTY;
                entry_count <= 7'(count);
              end else begin
                state <= S_RM_LOAD;
              end
            end
          end
        end
        S_UP: begin
          if (up_stop) begin
            count       <= count + CW'(1);
            done        <= 1'b1;
            status      <= STATUS_OK;
            entry_count <= 7'(count + CW'(1));
            state       <= S_IDLE;
          end else begin
            pos <= parent;
          end
        end
        S_RM_LOAD: begin
          removed_key <= rdata_a;
          hold_key    <= rdata_b;
          pos         <= '0;
          count       <= count_m1;
          if (count_m1 == '0) begin
            done        <= 1'b1;
            status      <= STATUS_OK;
            entry_count <= 7'(count_m1);
            state       <= S_IDLE;
          end else begin
            state <= S_DOWN;
          end
        end
        S_DOWN: begin
          if (down_move) begin
            pos <= pick_pos;
          end else begin
            done        <= 1'b1;
            status      <= STATUS_OK;
            entry_count <= 7'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---- assertions ----
  logic rm_on_empty;
  logic empty_done;
  logic full_done;
  assign rm_on_empty = accept && (command == CMD_REMOVE) && (count == '0);
  assign empty_done  = done && (status == STATUS_EMPTY);
  assign full_done   = done && (status == STATUS_FULL);

  `ASSERT_CLK(a_done_when_idle, done |-> (state == S_IDLE), "result strobe while still working")
  `ASSERT_CLK(a_count_bound, count <= CW'(CAPACITY), "entry count above capacity")
  `ASSERT_CLK(a_empty_remove, rm_on_empty |=> empty_done, "empty remove not reported next cycle")
  `ASSERT_CLK(a_full_insert, full_done |-> (count == CW'(CAPACITY)), "full reported while not full")
  `ASSERT_CLK(a_down_in_range, (state == S_DOWN) |-> (pos < AW'(count)), "sift-down hole outside heap")

endmodule

`default_nettype wire

### design/mhpq_ram.sv
// Heap key store: one write port, two read ports, registered read data.
// Depends on mhpq_pkg for the key type.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
  parameter int DEPTH = mhpq_pkg::DEFAULT_CAPACITY,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire mhpq_pkg::key_t   wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output mhpq_pkg::key_t        rdata_a,
  output mhpq_pkg::key_t        rdata_b
);
  import mhpq_pkg::*;

  key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // addresses past the depth return don't-care data; the controller ignores it
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

### test/max_heap_priority_queue_top_tb.sv
// Self-checking testbench for the max-heap priority queue top level.
// Depends on mhpq_pkg and max_heap_priority_queue_top; carries its own heap predictor.
`timescale 1ns / 1ps

module max_heap_priority_queue_top_tb;
  import mhpq_pkg::*;

  localparam int HEAP_DEPTH = DEFAULT_CAPACITY;
  // Slowest request is one full sift plus the longest random sender gap;
  // this many cycles with no request and no result means the block is hung.
  localparam int QUIET_LIMIT = 2000;
  // Settle time after the last result, well past the longest sift.
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    key_t       removed;
    status_t    status;
    logic [6:0] count;
  } heap_reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       command = CMD_INSERT;
  key_t       key = '0;
  logic       busy;
  logic       done;
  key_t       removed_key;
  status_t    status;
  logic [6:0] entry_count;

  max_heap_priority_queue_top #(.CAPACITY(HEAP_DEPTH)) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .key        (key),
    .done       (done),
    .removed_key(removed_key),
    .status     (status),
    .entry_count(entry_count)
  );

  always #5 clk = ~clk;

  // Predictor state: our own copy of the heap and its fill level.
  key_t        model_heap [HEAP_DEPTH];
  int          model_fill = 0;
  heap_reply_t pending_replies [$];
  int          error_count = 0;
  bit          sender_idles = 1'b0;  // random gaps before some requests
  int          stim_level = 0;       // fill level as seen by the stimulus side

  // Apply one request to the predicted heap and return the reply it must give.
  function automatic heap_reply_t apply_request(input logic cmd, input key_t k);
    heap_reply_t r;
    int          i;
    int          p;
    int          c;
    key_t        moving;
    r.removed = '0;
    r.status  = STATUS_OK;
    if (cmd == CMD_INSERT) begin
      if (model_fill >= HEAP_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        // sift up: stop on a parent that is equal or larger
        i = model_fill;
        while (i > 0) begin
          p = (i - 1) / 2;
          if (!(k > model_heap[p])) break;
          model_heap[i] = model_heap[p];
          i = p;
        end
        model_heap[i] = k;
        model_fill++;
      end
    end else begin
      if (model_fill == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.removed = model_heap[0];
        model_fill--;
        moving = model_heap[model_fill];
        if (model_fill > 0) begin
          // sift down: left child wins ties, move only on a strictly larger child
          i = 0;
          forever begin
            c = 2 * i + 1;
            if (c >= model_fill) break;
            if (c + 1 < model_fill && model_heap[c + 1] > model_heap[c]) c = c + 1;
            if (!(model_heap[c] > moving)) break;
            model_heap[i] = model_heap[c];
            i = c;
          end
          model_heap[i] = moving;
        end
      end
    end
    r.count = model_fill[6:0];
    return r;
  endfunction

  // Request acceptance: predict at the same edge the block takes the request.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      pending_replies = {pending_replies, apply_request(command, key)};
    end
  end

  // Result checker: every done strobe is matched against the oldest prediction.
  always @(posedge clk) begin
    heap_reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result: removed_key %0d status %0d entry_count %0d",
                 $time, removed_key, status, entry_count);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (removed_key !== want.removed) begin
          $display("%0t: removed_key expected %0d actual %0d", $time, want.removed,
                   removed_key);
          error_count++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          error_count++;
        end
        if (entry_count !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                   entry_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither a request nor a result moves.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request and hold it until the block takes it. Called and
  // returns in the step of a rising edge; start stays high for the next call.
  task automatic send_request(input logic cmd, input key_t k);
    if (sender_idles && $urandom_range(99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start   <= 1'b1;
    command <= cmd;
    key     <= k;
    do @(posedge clk); while (busy);
    if (cmd == CMD_INSERT) begin
      if (stim_level < HEAP_DEPTH) stim_level++;
    end else if (stim_level > 0) begin
      stim_level--;
    end
  endtask

  // Key mix: extremes, a narrow band that forces duplicates, and full-range values.
  function automatic key_t pick_key();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1, 2, 3: return key_t'($signed($urandom_range(16)) - 8);
      default: return key_t'($urandom);
    endcase
  endfunction

  // Remove from an empty heap after reset.
  task automatic test_empty_remove();
    send_request(CMD_REMOVE, key_t'($urandom));
  endtask

  // Most positive, most negative, zero and around zero, then drain past empty.
  task automatic test_key_extremes();
    key_t edge_keys [7] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sh1, 32'sh1,
                            32'sh7FFF_FFFF, 32'sh8000_0000};
    foreach (edge_keys[n]) send_request(CMD_INSERT, edge_keys[n]);
    repeat (8) send_request(CMD_REMOVE, 32'sh0);
  endtask

  // Duplicate keys exercise the tie rules of both sift directions.
  task automatic test_equal_keys();
    send_request(CMD_INSERT, 32'sd5);
    send_request(CMD_INSERT, 32'sd5);
    send_request(CMD_INSERT, 32'sd5);
    send_request(CMD_INSERT, 32'sd7);
    repeat (5) send_request(CMD_REMOVE, 32'sh0);
  endtask

  // Fill to capacity, insert into a full heap, then drain one past empty.
  task automatic test_full_heap();
    repeat (HEAP_DEPTH) send_request(CMD_INSERT, pick_key());
    repeat (2) send_request(CMD_INSERT, pick_key());
    repeat (HEAP_DEPTH + 1) send_request(CMD_REMOVE, key_t'($urandom));
  endtask

  // Random traffic in bursts that lean toward growing, shrinking or holding.
  task automatic test_random_traffic(input int n_requests);
    int sent = 0;
    int burst;
    int insert_pct;
    while (sent < n_requests) begin
      burst = $urandom_range(20, 120);
      case ($urandom_range(2))
        0: insert_pct = 80;
        1: insert_pct = 20;
        default: insert_pct = 50;
      endcase
      repeat (burst) begin
        if (sent >= n_requests) break;
        if ($urandom_range(99) < insert_pct) send_request(CMD_INSERT, pick_key());
        else send_request(CMD_REMOVE, key_t'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_remove();
    test_key_extremes();
    test_equal_keys();
    sender_idles = 1'b1;
    test_full_heap();
    // back-to-back stretch, then the bulk with random sender gaps
    sender_idles = 1'b0;
    test_random_traffic(300);
    sender_idles = 1'b1;
    test_random_traffic(1295);
    start <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/mhpq_pkg.sv
design/mhpq_ram.sv
design/max_heap_priority_queue_top.sv
test/max_heap_priority_queue_top_tb.sv
